### rtl/rate_monotonic_tick_scheduler_assert.svh
// Assertion macros shared by the scheduler RTL.
`ifndef RATE_MONOTONIC_TICK_SCHEDULER_ASSERT_SVH
`define RATE_MONOTONIC_TICK_SCHEDULER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define RMTS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define RMTS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/rmts_pkg.sv
// Types and constants of the rate-monotonic tick scheduler.
`default_nettype none

package rmts_pkg;

   // Table geometry and field widths
   localparam int TASKS      = 8;
   localparam int TIME_BITS  = 16;
   localparam int WORK_BITS  = 24;
   localparam int STEP_BITS  = 32;
   localparam int SLOT_W     = 3;
   localparam int MASK_W     = 8;
   localparam int ADDR_W     = (TASKS > 1) ? $clog2(TASKS) : 1;
   localparam int SCAN_W     = $clog2(TASKS + 1);
   localparam int DIV_CNT_W  = $clog2(STEP_BITS);

   // Stream payload widths (rounded up to whole bytes)
   localparam int REQ_FIELDS_W = SLOT_W + 4 * TIME_BITS;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = 1 + SLOT_W + 2 * MASK_W + STEP_BITS;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Operation codes carried in req_tuser
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [WORK_BITS-1:0] WORK_MAX = '1;

   // One task table entry as held in the task memory
   typedef struct packed {
      logic [TIME_BITS-1:0] start;
      logic [TIME_BITS-1:0] period;
      logic [TIME_BITS-1:0] deadline;
      logic [TIME_BITS-1:0] exec;
      logic [WORK_BITS-1:0] remaining;
      logic [TIME_BITS-1:0] period_phase;    // elapsed mod period
      logic [TIME_BITS-1:0] deadline_phase;  // elapsed mod deadline
      logic                 started;
   } entry_type;

   // Result item, last field in the lowest bits
   typedef struct packed {
      logic [STEP_BITS-1:0] step_number;
      logic [MASK_W-1:0]    release_mask;
      logic [MASK_W-1:0]    deadline_miss_mask;
      logic [SLOT_W-1:0]    granted_task;
      logic                 granted_valid;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/rate_monotonic_tick_scheduler.sv
// Rate-monotonic tick scheduler: task table in memory, scanned once per tick.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_tvalid/tready     tuser: operation; tdata: slot and times
//   rsp_      out        rsp_tvalid/tready     tdata: grant, masks, step number
//
// A tick: the accepting state, a registered read of each table entry and its write-back,
// the grant write-back and the result state.
// A load: the accepting state, 32 steps of a bit-serial remainder of the steps elapsed
// since the task's start, for its phase in period and deadline, and the result state.
// Reset (synchronous) clears the step counter, the enable bits and the output.
// A waiting result does not block the next request; the result cycle after it stalls.
`default_nettype none

`include "rate_monotonic_tick_scheduler_assert.svh"

module rate_monotonic_tick_scheduler (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic                             req_tuser,  // operation
   // task_index, start_time, period, relative_deadline, exec_time, zero pad
   input  wire logic [rmts_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // granted_valid, granted_task, deadline_miss_mask, release_mask,
   // step_number, zero pad
   output logic [rmts_pkg::RSP_DATA_W-1:0]       rsp_tdata
);
   import rmts_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SCAN,
      ST_FINISH,
      ST_DONE
   } state_type;

   // Registers
   state_type                state_ff;
   logic [STEP_BITS-1:0]     step_ff;
   logic [TASKS-1:0]         enabled_ff;
   entry_type                ld_entry_ff;
   logic [ADDR_W-1:0]        ld_slot_ff;
   logic                     ld_ok_ff;
   logic [STEP_BITS-1:0]     dvd_ff;
   logic [TIME_BITS-1:0]     remp_ff;
   logic [TIME_BITS-1:0]     remd_ff;
   logic [DIV_CNT_W-1:0]     div_cnt_ff;
   logic [SCAN_W-1:0]        scan_cnt_ff;
   logic                     rd_vld_ff;
   logic [ADDR_W-1:0]        rd_idx_ff;
   entry_type                rd_data_ff;
   logic                     best_found_ff;
   logic [ADDR_W-1:0]        best_idx_ff;
   entry_type                best_entry_ff;
   logic [MASK_W-1:0]        miss_ff;
   logic [MASK_W-1:0]        rel_ff;
   logic                     rsp_tvalid_ff;
   rsp_type                  rsp_ff;

   entry_type                task_ram [TASKS];

   // Request field split
   logic                     req_xfer;
   logic [SLOT_W-1:0]        in_slot;
   logic [TIME_BITS-1:0]     in_start;
   logic [TIME_BITS-1:0]     in_period;
   logic [TIME_BITS-1:0]     in_deadline;
   logic [TIME_BITS-1:0]     in_exec;

   assign req_xfer    = req_tvalid && req_tready;
   assign in_slot     = req_tdata[SLOT_W-1:0];
   assign in_start    = req_tdata[SLOT_W +: TIME_BITS];
   assign in_period   = req_tdata[SLOT_W + TIME_BITS +: TIME_BITS];
   assign in_deadline = req_tdata[SLOT_W + 2*TIME_BITS +: TIME_BITS];
   assign in_exec     = req_tdata[SLOT_W + 3*TIME_BITS +: TIME_BITS];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_FIELDS_W){1'b0}}, rsp_ff};

   // Bit-serial remainder step for both divisors
   logic [TIME_BITS:0]       shp;
   logic [TIME_BITS:0]       shd;
   logic [TIME_BITS-1:0]     remp_in;
   logic [TIME_BITS-1:0]     remd_in;
   logic                     div_last;

   always_comb begin
      shp = {remp_ff, dvd_ff[STEP_BITS-1]};
      shd = {remd_ff, dvd_ff[STEP_BITS-1]};
      if (shp >= {1'b0, ld_entry_ff.period}) begin
         shp = shp - {1'b0, ld_entry_ff.period};
      end
      if (shd >= {1'b0, ld_entry_ff.deadline}) begin
         shd = shd - {1'b0, ld_entry_ff.deadline};
      end
      remp_in  = shp[TIME_BITS-1:0];
      remd_in  = shd[TIME_BITS-1:0];
      div_last = (div_cnt_ff == DIV_CNT_W'(STEP_BITS - 1));
   end

   // Per-entry tick update on the registered read data
   entry_type                upd;
   logic                     hit_start;
   logic                     act;
   logic [TIME_BITS:0]       rp_inc;
   logic [TIME_BITS:0]       rd_inc;
   logic                     rel_now;
   logic                     miss_now;
   logic [WORK_BITS:0]       work_sum;
   logic                     take_best;

   always_comb begin
      upd       = rd_data_ff;
      hit_start = (step_ff == {{(STEP_BITS - TIME_BITS){1'b0}}, rd_data_ff.start});
      act       = hit_start || (rd_data_ff.started && (step_ff != '0));
      rp_inc    = {1'b0, rd_data_ff.period_phase} + 1'b1;
      rd_inc    = {1'b0, rd_data_ff.deadline_phase} + 1'b1;
      if (hit_start || (rp_inc == {1'b0, rd_data_ff.period})) begin
         upd.period_phase = '0;
      end else begin
         upd.period_phase = rp_inc[TIME_BITS-1:0];
      end
      if (hit_start || (rd_inc == {1'b0, rd_data_ff.deadline})) begin
         upd.deadline_phase = '0;
      end else begin
         upd.deadline_phase = rd_inc[TIME_BITS-1:0];
      end
      upd.started = act;
      rel_now  = act && (rd_data_ff.period != '0) && (upd.period_phase == '0);
      miss_now = act && (rd_data_ff.deadline != '0) && (upd.deadline_phase == '0)
                 && (rd_data_ff.remaining != '0);
      work_sum = {1'b0, rd_data_ff.remaining}
                 + {{(WORK_BITS + 1 - TIME_BITS){1'b0}}, rd_data_ff.exec};
      if (rel_now) begin
         upd.remaining = work_sum[WORK_BITS] ? WORK_MAX : work_sum[WORK_BITS-1:0];
      end
      take_best = enabled_ff[rd_idx_ff] && (upd.remaining != '0)
                  && (!best_found_ff || (rd_data_ff.period < best_entry_ff.period));
   end

   // Memory write port select
   logic                     wr_en;
   logic [ADDR_W-1:0]        wr_addr;
   entry_type                wr_data;
   entry_type                ld_final;
   entry_type                best_dec;

   always_comb begin
      ld_final                = ld_entry_ff;
      ld_final.period_phase   = remp_in;
      ld_final.deadline_phase = remd_in;
      best_dec                = best_entry_ff;
      best_dec.remaining      = best_entry_ff.remaining - 1'b1;
      wr_en   = 1'b0;
      wr_addr = rd_idx_ff;
      wr_data = upd;
      unique case (state_ff)
         ST_DIV: begin
            wr_en   = div_last && ld_ok_ff;
            wr_addr = ld_slot_ff;
            wr_data = ld_final;
         end
         ST_SCAN: begin
            wr_en = rd_vld_ff && enabled_ff[rd_idx_ff];
         end
         ST_FINISH: begin
            wr_en   = best_found_ff;
            wr_addr = best_idx_ff;
            wr_data = best_dec;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // Task memory: one write and one registered read per cycle; a tick reads
   // each entry once and writes it back in the cycle after, so no entry is read
   // while its write is pending
   always_ff @(posedge clock) begin
      if (wr_en) begin
         task_ram[wr_addr] <= wr_data;
      end
      if ((state_ff == ST_SCAN) && (scan_cnt_ff < SCAN_W'(TASKS))) begin
         rd_data_ff <= task_ram[scan_cnt_ff[ADDR_W-1:0]];
      end
   end

   // Control, datapath and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= '0;
         enabled_ff    <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         best_found_ff <= 1'b0;
         scan_cnt_ff   <= '0;
         div_cnt_ff    <= '0;
      end else begin
         // result transfer frees the output unless a new result is loaded now
         if (rsp_tvalid_ff && rsp_tready && (state_ff != ST_DONE)) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  best_found_ff <= 1'b0;
                  miss_ff       <= '0;
                  rel_ff        <= '0;
                  if (req_tuser == OP_TICK) begin
                     step_ff     <= step_ff + 1'b1;
                     scan_cnt_ff <= '0;
                     state_ff    <= ST_SCAN;
                  end else begin
                     ld_ok_ff                <= ({1'b0, in_slot} < (SLOT_W + 1)'(TASKS));
                     ld_slot_ff              <= ADDR_W'(in_slot);
                     ld_entry_ff.start       <= in_start;
                     ld_entry_ff.period      <= in_period;
                     ld_entry_ff.deadline    <= in_deadline;
                     ld_entry_ff.exec        <= in_exec;
                     ld_entry_ff.remaining   <= '0;
                     ld_entry_ff.started     <=
                        (step_ff >= {{(STEP_BITS - TIME_BITS){1'b0}}, in_start});
                     ld_entry_ff.period_phase   <= '0;
                     ld_entry_ff.deadline_phase <= '0;
                     dvd_ff     <= step_ff - {{(STEP_BITS - TIME_BITS){1'b0}}, in_start};
                     remp_ff    <= '0;
                     remd_ff    <= '0;
                     div_cnt_ff <= '0;
                     state_ff   <= ST_DIV;
                  end
               end
            end
            ST_DIV: begin
               remp_ff    <= remp_in;
               remd_ff    <= remd_in;
               dvd_ff     <= {dvd_ff[STEP_BITS-2:0], 1'b0};
               div_cnt_ff <= div_cnt_ff + 1'b1;
               if (div_last) begin
                  if (ld_ok_ff) begin
                     enabled_ff[ld_slot_ff] <= 1'b1;
                  end
                  state_ff <= ST_DONE;
               end
            end
            ST_SCAN: begin
               // issue side
               rd_vld_ff <= (scan_cnt_ff < SCAN_W'(TASKS));
               rd_idx_ff <= scan_cnt_ff[ADDR_W-1:0];
               if (scan_cnt_ff < SCAN_W'(TASKS)) begin
                  scan_cnt_ff <= scan_cnt_ff + 1'b1;
               end else begin
                  state_ff <= ST_FINISH;
               end
               // update side
               if (rd_vld_ff && enabled_ff[rd_idx_ff]) begin
                  if (miss_now) begin
                     miss_ff <= miss_ff | (MASK_W'(1) << rd_idx_ff);
                  end
                  if (rel_now) begin
                     rel_ff <= rel_ff | (MASK_W'(1) << rd_idx_ff);
                  end
                  if (take_best) begin
                     best_found_ff <= 1'b1;
                     best_idx_ff   <= rd_idx_ff;
                     best_entry_ff <= upd;
                  end
               end
            end
            ST_FINISH: begin
               rd_vld_ff <= 1'b0;
               state_ff  <= ST_DONE;
            end
            ST_DONE: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff             <= 1'b1;
                  rsp_ff.granted_valid      <= best_found_ff;
                  rsp_ff.granted_task       <= best_found_ff ? SLOT_W'(best_idx_ff) : '0;
                  rsp_ff.deadline_miss_mask <= miss_ff;
                  rsp_ff.release_mask       <= rel_ff;
                  rsp_ff.step_number        <= step_ff;
                  state_ff                  <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Checks
   logic [MASK_W-1:0] en_mask;
   assign en_mask = MASK_W'(enabled_ff);

   `RMTS_ASSERT_NEXT(a_busy_after_xfer, clock, reset, req_xfer, !req_tready, "accepted twice")
   `RMTS_ASSERT_NOW(a_grant_enabled, clock, reset,
      rsp_tvalid_ff && rsp_ff.granted_valid, en_mask[rsp_ff.granted_task],
      "grant to disabled slot")
   `RMTS_ASSERT_NOW(a_release_enabled, clock, reset,
      rsp_tvalid_ff, (rsp_ff.release_mask & ~en_mask) == '0,
      "release of disabled slot")
   `RMTS_ASSERT_NOW(a_scan_no_load, clock, reset,
      wr_en && (state_ff == ST_SCAN), rd_vld_ff,
      "write-back without read data")

endmodule

`default_nettype wire

### bench/rate_monotonic_tick_scheduler_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the rate-monotonic tick scheduler, with a built-in scheduler mirror.

module rate_monotonic_tick_scheduler_tb;
   import rmts_pkg::*;

   localparam int TOTAL_ITEMS    = 1850;
   localparam int CALM_ITEMS     = 160;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 80;

   // One request as the bench sees it, before packing
   typedef struct {
      logic                 op;
      logic [SLOT_W-1:0]    slot;
      logic [TIME_BITS-1:0] start;
      logic [TIME_BITS-1:0] period;
      logic [TIME_BITS-1:0] deadline;
      logic [TIME_BITS-1:0] exec;
   } sched_item_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic                  req_tuser;   // operation
   // task_index, start_time, period, relative_deadline, exec_time, zero pad
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // granted_valid, granted_task, deadline_miss_mask, release_mask, step_number, zero pad
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // Mirror of the scheduler state
   logic [STEP_BITS-1:0] step_count;
   logic                 slot_enabled  [TASKS];
   logic [TIME_BITS-1:0] slot_start    [TASKS];
   logic [TIME_BITS-1:0] slot_period   [TASKS];
   logic [TIME_BITS-1:0] slot_deadline [TASKS];
   logic [TIME_BITS-1:0] slot_exec     [TASKS];
   logic [WORK_BITS-1:0] slot_work     [TASKS];

   rsp_type pending_grants[$];
   rsp_type got_rsp;
   rsp_type want_rsp;
   int      items_sent;
   int      error_count;
   int      idle_cycles;
   bit      pace_on;

   rate_monotonic_tick_scheduler u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 50 MHz clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Expected result of one request; updates the mirror
   function automatic rsp_type predict_grant(input sched_item_type it);
      rsp_type              r;
      logic [STEP_BITS-1:0] start_ext;
      logic [STEP_BITS-1:0] period_ext;
      logic [STEP_BITS-1:0] deadline_ext;
      logic [STEP_BITS-1:0] elapsed;
      logic [WORK_BITS:0]   sum;
      logic [TIME_BITS-1:0] best_period;
      bit                   found;
      r = '0;
      if (it.op == OP_LOAD) begin
         slot_enabled[it.slot]  = 1'b1;
         slot_start[it.slot]    = it.start;
         slot_period[it.slot]   = it.period;
         slot_deadline[it.slot] = it.deadline;
         slot_exec[it.slot]     = it.exec;
         slot_work[it.slot]     = '0;
         r.step_number = step_count;
         return r;
      end
      step_count = step_count + 1'b1;
      // misses see the work left over from before this tick's release
      for (int i = 0; i < TASKS; i++) begin
         start_ext    = STEP_BITS'(slot_start[i]);
         period_ext   = STEP_BITS'(slot_period[i]);
         deadline_ext = STEP_BITS'(slot_deadline[i]);
         if (slot_enabled[i] && step_count >= start_ext) begin
            elapsed = step_count - start_ext;
            if (deadline_ext != 0 && elapsed % deadline_ext == 0 && slot_work[i] != '0)
               r.deadline_miss_mask[i] = 1'b1;
            if (period_ext != 0 && elapsed % period_ext == 0) begin
               r.release_mask[i] = 1'b1;
               sum = {1'b0, slot_work[i]} + (WORK_BITS + 1)'(slot_exec[i]);
               slot_work[i] = sum[WORK_BITS] ? WORK_MAX : sum[WORK_BITS-1:0];
            end
         end
      end
      // shortest period wins, lower index on a tie
      found = 1'b0;
      best_period = '0;
      for (int i = 0; i < TASKS; i++) begin
         if (slot_enabled[i] && slot_work[i] != '0 && (!found || slot_period[i] < best_period)) begin
            found = 1'b1;
            best_period = slot_period[i];
            r.granted_task = i[SLOT_W-1:0];
         end
      end
      if (found) begin
         r.granted_valid = 1'b1;
         slot_work[r.granted_task] = slot_work[r.granted_task] - 1'b1;
      end
      r.step_number = step_count;
      return r;
   endfunction

   function automatic sched_item_type make_load(input int slot, input int start, input int period,
                                                input int deadline, input int exec);
      sched_item_type it;
      it.op       = OP_LOAD;
      it.slot     = slot[SLOT_W-1:0];
      it.start    = start[TIME_BITS-1:0];
      it.period   = period[TIME_BITS-1:0];
      it.deadline = deadline[TIME_BITS-1:0];
      it.exec     = exec[TIME_BITS-1:0];
      return it;
   endfunction

   // Tick with junk in the ignored fields
   function automatic sched_item_type random_tick();
      sched_item_type it;
      it = make_load($urandom, $urandom, $urandom, $urandom, $urandom);
      it.op = OP_TICK;
      return it;
   endfunction

   // Mostly small task sets that run inside the test; some loads with arbitrary fields
   function automatic sched_item_type random_load();
      sched_item_type it;
      int unsigned horizon;
      it = make_load($urandom_range(0, TASKS - 1), 0, 0, 0, 0);
      if ($urandom_range(0, 7) == 0) begin
         it.start    = TIME_BITS'($urandom);
         it.period   = TIME_BITS'($urandom);
         it.deadline = TIME_BITS'($urandom);
         it.exec     = TIME_BITS'($urandom);
      end else begin
         horizon = step_count + 24;
         if (horizon > 65535) horizon = 65535;
         it.start    = TIME_BITS'($urandom_range(0, horizon));
         it.period   = ($urandom_range(0, 19) == 0) ? '0 : TIME_BITS'($urandom_range(1, 32));
         it.deadline = ($urandom_range(0, 19) == 0) ? '0 : TIME_BITS'($urandom_range(1, 36));
         it.exec     = TIME_BITS'($urandom_range(0, 4));
      end
      return it;
   endfunction

   // Present one request and wait for its transfer
   task automatic send_item(input sched_item_type it);
      if (pace_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.op;
      req_tdata  <= {{(REQ_DATA_W - REQ_FIELDS_W){1'b0}},
                     it.exec, it.deadline, it.period, it.start, it.slot};
      do @(posedge clock); while (!req_tready);
      pending_grants.insert(pending_grants.size(), predict_grant(it));
      items_sent++;
   endtask

   // Hold off the sender until every result is back
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_grants.size() != 0);
   endtask

   // Ticks on an empty table
   task automatic test_idle_ticks();
      repeat (2) send_item(random_tick());
   endtask

   // Ties, zero period, zero deadline, late start, zero work, full-range fields, reload
   task automatic test_directed_cases();
      send_item(make_load(0, 0, 3, 2, 2));
      send_item(make_load(5, 0, 3, 2, 2));
      send_item(make_load(3, 0, 0, 5, 7));
      send_item(make_load(4, 0, 4, 0, 9));
      send_item(make_load(6, step_count + 4, 2, 2, 1));
      send_item(make_load(7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_item(make_load(1, 0, 5, 5, 0));
      wait_for_results();
      repeat (10) send_item(random_tick());
      // reload while work is pending
      send_item(make_load(4, 0, 7, 7, 1));
      repeat (4) send_item(random_tick());
   endtask

   // Period 1 with the largest work per release drives the work counter into saturation
   task automatic test_work_saturation();
      send_item(make_load(0, step_count, 1, 1, 16'hFFFF));
      repeat (262) send_item(random_tick());
      send_item(make_load(0, 0, 8, 8, 1));
   endtask

   // Random task sets, each followed by a run of ticks with the odd stray reload
   task automatic test_random_task_sets(input int target);
      while (items_sent < target) begin
         repeat ($urandom_range(1, 4)) send_item(random_load());
         if ($urandom_range(0, 9) == 0) wait_for_results();
         repeat ($urandom_range(8, 50)) begin
            if ($urandom_range(0, 29) == 0) send_item(random_load());
            send_item(random_tick());
         end
      end
   endtask

   // Closing stretch at full rate on both sides
   task automatic test_back_to_back(input int count);
      int stop_at;
      stop_at = items_sent + count;
      pace_on = 1'b0;
      repeat (4) send_item(random_load());
      while (items_sent < stop_at) send_item(random_tick());
   endtask

   task automatic check_field(input string name, input logic [STEP_BITS-1:0] want,
                              input logic [STEP_BITS-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endtask

   // Receiver stalls in bursts
   initial begin
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         if (pace_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   // Result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_rsp = rsp_type'(rsp_tdata[RSP_FIELDS_W-1:0]);
         if (pending_grants.size() == 0) begin
            $error("result transfer with nothing expected: %0h", got_rsp);
            error_count++;
         end else begin
            want_rsp = pending_grants.pop_front();
            check_field("granted_valid", STEP_BITS'(want_rsp.granted_valid),
                        STEP_BITS'(got_rsp.granted_valid));
            check_field("granted_task", STEP_BITS'(want_rsp.granted_task),
                        STEP_BITS'(got_rsp.granted_task));
            check_field("deadline_miss_mask", STEP_BITS'(want_rsp.deadline_miss_mask),
                        STEP_BITS'(got_rsp.deadline_miss_mask));
            check_field("release_mask", STEP_BITS'(want_rsp.release_mask),
                        STEP_BITS'(got_rsp.release_mask));
            check_field("step_number", want_rsp.step_number, got_rsp.step_number);
         end
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      pace_on     = 1'b1;
      items_sent  = 0;
      step_count  = '0;
      for (int i = 0; i < TASKS; i++) begin
         slot_enabled[i]  = 1'b0;
         slot_start[i]    = '0;
         slot_period[i]   = '0;
         slot_deadline[i] = '0;
         slot_exec[i]     = '0;
         slot_work[i]     = '0;
      end
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= 1'b0;
      req_tdata  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_idle_ticks();
      test_directed_cases();
      test_work_saturation();
      test_random_task_sets(TOTAL_ITEMS - CALM_ITEMS);
      test_back_to_back(CALM_ITEMS);

      // drain and settle
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
